>>> rtl/core/bdbm_pkg.sv
// ----------------------------------------------------------------------------
// bdbm_pkg
// shared types, target codes and boot image for the bank mapper
// ----------------------------------------------------------------------------
`default_nettype none
package bdbm_pkg;

    typedef enum logic [3:0] {
        TGT_NONE  = 4'd0,
        TGT_BOOT  = 4'd1,
        TGT_ROM   = 4'd2,
        TGT_VRAM  = 4'd3,
        TGT_XRAM  = 4'd4,
        TGT_WRAM  = 4'd5,
        TGT_OAM   = 4'd6,
        TGT_JOYP  = 4'd7,
        TGT_TIMER = 4'd8,
        TGT_VIDEO = 4'd9,
        TGT_IF    = 4'd10,
        TGT_IE    = 4'd11,
        TGT_HRAM  = 4'd12,
        TGT_BANK  = 4'd13
    } t_target;

    // classified request from front to back
    typedef struct packed {
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
        t_target     tgt;
        logic        leave_boot;
    } t_req;

    typedef struct packed {
        t_target     tgt;
        logic [20:0] phys;
        logic        fwd;
        logic [7:0]  fdata;
        logic [7:0]  rdata;
        logic        ram_en;
    } t_res;

    localparam int HIGH_RAM_DEPTH = 128;

    localparam logic [15:0] BOOT_EXIT_PC = 16'h0100;

    function automatic logic [7:0] boot_rom(input logic [7:0] a);
        logic [7:0] img [256];
        img = '{
8'h31,8'hFE,8'hFF,8'hAF,8'h21,8'hFF,8'h9F,8'h32,8'hCB,8'h7C,8'h20,8'hFB,8'h21,8'h26,8'hFF,8'h0E,
8'h11,8'h3E,8'h80,8'h32,8'hE2,8'h0C,8'h3E,8'hF3,8'hE2,8'h32,8'h3E,8'h77,8'h77,8'h3E,8'hFC,8'hE0,
8'h47,8'h11,8'h04,8'h01,8'h21,8'h10,8'h80,8'h1A,8'hCD,8'h95,8'h00,8'hCD,8'h96,8'h00,8'h13,8'h7B,
8'hFE,8'h34,8'h20,8'hF3,8'h11,8'hD8,8'h00,8'h06,8'h08,8'h1A,8'h13,8'h22,8'h23,8'h05,8'h20,8'hF9,
8'h3E,8'h19,8'hEA,8'h10,8'h99,8'h21,8'h2F,8'h99,8'h0E,8'h0C,8'h3D,8'h28,8'h08,8'h32,8'h0D,8'h20,
8'hF9,8'h2E,8'h0F,8'h18,8'hF3,8'h67,8'h3E,8'h64,8'h57,8'hE0,8'h42,8'h3E,8'h91,8'hE0,8'h40,8'h04,
8'h1E,8'h02,8'h0E,8'h0C,8'hF0,8'h44,8'hFE,8'h90,8'h20,8'hFA,8'h0D,8'h20,8'hF7,8'h1D,8'h20,8'hF2,
8'h0E,8'h13,8'h24,8'h7C,8'h1E,8'h83,8'hFE,8'h62,8'h28,8'h06,8'h1E,8'hC1,8'hFE,8'h64,8'h20,8'h06,
8'h7B,8'hE2,8'h0C,8'h3E,8'h87,8'hF2,8'hF0,8'h42,8'h90,8'hE0,8'h42,8'h15,8'h20,8'hD2,8'h05,8'h20,
8'h4F,8'h16,8'h20,8'h18,8'hCB,8'h4F,8'h06,8'h04,8'hC5,8'hCB,8'h11,8'h17,8'hC1,8'hCB,8'h11,8'h17,
8'h05,8'h20,8'hF5,8'h22,8'h23,8'h22,8'h23,8'hC9,8'hCE,8'hED,8'h66,8'h66,8'hCC,8'h0D,8'h00,8'h0B,
8'h03,8'h73,8'h00,8'h83,8'h00,8'h0C,8'h00,8'h0D,8'h00,8'h08,8'h11,8'h1F,8'h88,8'h89,8'h00,8'h0E,
8'hDC,8'hCC,8'h6E,8'hE6,8'hDD,8'hDD,8'hD9,8'h99,8'hBB,8'hBB,8'h67,8'h63,8'h6E,8'h0E,8'hEC,8'hCC,
8'hDD,8'hDC,8'h99,8'h9F,8'hBB,8'hB9,8'h33,8'h3E,8'h3C,8'h42,8'hB9,8'hA5,8'hB9,8'hA5,8'h42,8'h4C,
8'h21,8'h04,8'h01,8'h11,8'hA8,8'h00,8'h1A,8'h13,8'hBE,8'h20,8'hFE,8'h23,8'h7D,8'hFE,8'h34,8'h20,
8'hF5,8'h06,8'h19,8'h78,8'h86,8'h23,8'h05,8'h20,8'hFB,8'h86,8'h20,8'hFE,8'h3E,8'h01,8'hE0,8'h50
        };
        return img[a];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/bus_decoder_bank_mapper_unit.sv
// ----------------------------------------------------------------------------
// empty falls when an accepted request has passed the queue into the result register
// throughput: one request per cycle while pop keeps up; full holds off push otherwise
// reset: synchronous active low; bank, interrupt and overlay state reset at once,
// never-written high ram entries read zero, entry 5 0xFF, through valid bits
// ----------------------------------------------------------------------------
`default_nettype none
module bus_decoder_bank_mapper_unit import bdbm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_action,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_byte,
    input  wire logic [15:0] i_cpu_pc,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       o_target,
    output logic [20:0]      o_phys_address,
    output logic             o_forward_write,
    output logic [7:0]       o_forward_data,
    output logic [7:0]       o_read_byte,
    output logic             o_ram_enabled
);
    localparam int AW = $clog2(HIGH_RAM_DEPTH);

    logic r_mbc1;
    logic w_take;
    t_req w_freq;
    t_req w_qreq;
    t_req w_breq;
    logic w_qempty;
    logic w_bvalid;
    logic w_btake;
    t_res w_res;
    logic [HIGH_RAM_DEPTH-1:0] r_hv;
    logic r_hmiss;
    logic [AW-1:0] w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbc1 <= 1'b0;
        end else if (i_cfg_we) begin
            r_mbc1 <= i_cfg_data;
        end
    end

    assign w_take = push && !full;

    bdbm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take), .i_wr(i_action),
        .i_addr(i_address), .i_data(i_write_byte), .i_pc(i_cpu_pc), .o_req(w_freq)
    );

    bdbm_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_req(w_freq), .o_full(full),
        .i_pop(w_btake), .o_empty(w_qempty), .o_req(w_qreq)
    );

    assign w_breq = w_qreq;
    assign w_idx  = w_qreq.addr[AW-1:0];

    bdbm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mbc1(r_mbc1), .i_valid(!w_qempty),
        .i_req(w_breq), .o_take(w_btake), .o_valid(w_bvalid), .i_pop(pop),
        .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= '0;
        end else if (w_btake && w_qreq.tgt == TGT_HRAM && w_qreq.wr) begin
            r_hv[w_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_btake) r_hmiss <= (w_qreq.tgt == TGT_HRAM) && !w_qreq.wr && !r_hv[w_idx];
    end

    assign empty           = !w_bvalid;
    assign o_target        = w_res.tgt;
    assign o_phys_address  = w_res.phys;
    assign o_forward_write = w_res.fwd;
    assign o_forward_data  = w_res.fdata;
    assign o_read_byte     = r_hmiss ? ((o_phys_address[6:0] == 7'd5) ? 8'hFF : 8'h00)
                                     : w_res.rdata;
    assign o_ram_enabled   = w_res.ram_en;
endmodule
`default_nettype wire

>>> rtl/core/bdbm_front.sv
// ----------------------------------------------------------------------------
// bdbm_front
// address map decode and boot overlay tracking
// ----------------------------------------------------------------------------
`default_nettype none
module bdbm_front import bdbm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic        i_wr,
    input  wire logic [15:0] i_addr,
    input  wire logic [7:0]  i_data,
    input  wire logic [15:0] i_pc,
    output t_req             o_req
);
    logic    r_boot;
    logic    n_boot;
    t_target w_tgt;
    logic [7:0] w_lo;
    logic    w_leave;

    assign w_lo = i_addr[7:0];

    always_comb begin
        w_tgt   = TGT_NONE;
        w_leave = 1'b0;
        if (!i_addr[15]) begin
            if (i_wr) begin
                w_tgt = TGT_BANK;
            end else if (r_boot && i_addr[15:8] == 8'h00) begin
                w_tgt = TGT_BOOT;
            end else begin
                w_tgt   = TGT_ROM;
                w_leave = (i_addr[15:12] == 4'h0) && r_boot && (i_pc == BOOT_EXIT_PC);
            end
        end else if (i_addr[15:13] == 3'b100) begin
            w_tgt = TGT_VRAM;
        end else if (i_addr[15:13] == 3'b101) begin
            w_tgt = TGT_XRAM;
        end else if (i_addr < 16'hFE00) begin
            w_tgt = TGT_WRAM;
        end else if (i_addr[15:8] == 8'hFE) begin
            if (w_lo < 8'hA0) w_tgt = TGT_OAM;
        end else if (w_lo == 8'h00) begin
            w_tgt = TGT_JOYP;
        end else if (w_lo == 8'h0F) begin
            w_tgt = TGT_IF;
        end else if (w_lo >= 8'h04 && w_lo <= 8'h07) begin
            w_tgt = TGT_TIMER;
        end else if (w_lo >= 8'h40 && w_lo <= 8'h7F) begin
            w_tgt = TGT_VIDEO;
        end else if (w_lo == 8'hFF) begin
            w_tgt = TGT_IE;
        end else if (w_lo[7]) begin
            w_tgt = TGT_HRAM;
        end
    end

    assign n_boot = (i_take && w_leave) ? 1'b0 : r_boot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot <= 1'b1;
        end else begin
            r_boot <= n_boot;
        end
    end

    assign o_req = '{wr: i_wr, addr: i_addr, data: i_data, tgt: w_tgt, leave_boot: w_leave};
endmodule
`default_nettype wire

>>> rtl/core/bdbm_queue.sv
// ----------------------------------------------------------------------------
// bdbm_queue
// two-entry register queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module bdbm_queue import bdbm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_req,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_req      o_req
);
    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt[1];
    assign o_empty = (r_cnt == 2'd0);
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_pop && !o_empty};
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/bdbm_back.sv
// ----------------------------------------------------------------------------
// bdbm_back
// bank registers, interrupt bytes, high ram and result register
// ----------------------------------------------------------------------------
`default_nettype none
module bdbm_back import bdbm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_mbc1,
    input  wire logic i_valid,
    input  wire t_req i_req,
    output logic      o_take,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_res      o_res
);
    localparam int AW = $clog2(HIGH_RAM_DEPTH);

    logic [6:0] r_rom_bank;
    logic [6:0] r_win_bank;
    logic [1:0] r_ram_bank;
    logic       r_mode;
    logic       r_ram_en;
    logic [7:0] r_ie;
    logic [7:0] r_if;
    logic [7:0] r_hram [HIGH_RAM_DEPTH];
    logic       r_valid;
    t_res       r_res;
    logic       r_hsel;
    logic [7:0] r_hdata;
    t_res       n_res;
    logic       w_go;
    logic [AW-1:0] w_idx;
    logic [4:0] w_low;
    logic       w_bank;

    assign o_take  = i_valid && (!r_valid || i_pop);
    assign w_go    = o_take;
    assign o_valid = r_valid;
    assign w_idx   = i_req.addr[AW-1:0];
    assign w_low   = (i_req.data[4:0] == 5'd0) ? 5'd1 : i_req.data[4:0];
    assign w_bank  = w_go && i_req.tgt == TGT_BANK && i_mbc1;

    always_comb begin
        n_res = '0;
        n_res.tgt = i_req.tgt;
        unique case (i_req.tgt)
            TGT_BOOT, TGT_BANK: n_res.phys = {5'd0, i_req.addr};
            TGT_ROM: n_res.phys = i_req.addr[14] ?
                {r_win_bank, i_req.addr[13:0]} : {5'd0, i_req.addr};
            TGT_VRAM, TGT_WRAM: n_res.phys = {8'd0, i_req.addr[12:0]};
            TGT_XRAM: n_res.phys = {6'd0, r_ram_bank, i_req.addr[12:0]};
            TGT_HRAM: n_res.phys = {14'd0, i_req.addr[6:0]};
            TGT_NONE: n_res.phys = '0;
            default: n_res.phys = {13'd0, i_req.addr[7:0]};
        endcase
        n_res.fwd = i_req.wr && (i_req.tgt inside {TGT_VRAM, TGT_XRAM, TGT_WRAM,
            TGT_OAM, TGT_JOYP, TGT_TIMER, TGT_VIDEO});
        n_res.fdata = n_res.fwd ? i_req.data : 8'd0;
        if (!i_req.wr) begin
            case (i_req.tgt)
                TGT_BOOT: n_res.rdata = boot_rom(i_req.addr[7:0]);
                TGT_IF:   n_res.rdata = r_if;
                TGT_IE:   n_res.rdata = r_ie;
                default:  n_res.rdata = 8'd0;
            endcase
        end
        n_res.ram_en = r_ram_en;
        if (w_bank && i_req.addr[14:13] == 2'd0) n_res.ram_en = (i_req.data[3:0] == 4'hA);
    end

    always_ff @(posedge i_clk) begin
        if (w_go && i_req.tgt == TGT_HRAM && i_req.wr) r_hram[w_idx] <= i_req.data;
        if (w_go) begin
            r_hdata <= r_hram[w_idx];
            r_res   <= n_res;
            r_hsel  <= (i_req.tgt == TGT_HRAM) && !i_req.wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_rom_bank <= 7'd0;
            r_win_bank <= 7'd1;
            r_ram_bank <= 2'd0;
            r_mode     <= 1'b0;
            r_ram_en   <= 1'b0;
            r_ie       <= 8'd0;
            r_if       <= 8'd0;
        end else begin
            if (w_go) r_valid <= 1'b1;
            else if (i_pop) r_valid <= 1'b0;
            if (w_bank) begin
                case (i_req.addr[14:13])
                    2'd0: r_ram_en <= n_res.ram_en;
                    2'd1: begin
                        r_rom_bank <= {r_rom_bank[6:5], w_low};
                        r_win_bank <= {r_rom_bank[6:5], w_low};
                    end
                    2'd2: begin
                        if (r_mode) begin
                            r_ram_bank <= i_req.data[1:0];
                        end else begin
                            r_rom_bank <= {i_req.data[1:0], r_rom_bank[4:0]};
                            r_win_bank <= {i_req.data[1:0], r_rom_bank[4:0]};
                        end
                    end
                    default: r_mode <= i_req.data[0];
                endcase
            end
            if (w_go && i_req.wr && i_req.tgt == TGT_IF) r_if <= i_req.data;
            if (w_go && i_req.wr && i_req.tgt == TGT_IE) r_ie <= i_req.data;
        end
    end

    // high ram reset image: zero, entry 5 is 0xFF; supplied by valid bits in top
    always_comb begin
        o_res = r_res;
        if (r_hsel) o_res.rdata = r_hdata;
    end
endmodule
`default_nettype wire

>>> rtl/core/bdbm_checker.sv
// ----------------------------------------------------------------------------
// bdbm_checker
// port-level checks on the bank mapper result stream
// ----------------------------------------------------------------------------
`default_nettype none
module bdbm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [3:0]  o_target,
    input wire logic        o_forward_write,
    input wire logic [7:0]  o_forward_data,
    input wire logic [20:0] o_phys_address
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_target)) else $error("result dropped");
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_forward_write |-> o_forward_data == 8'd0) else $error("fwd data");
    a_tgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_target <= 4'd13) else $error("bad target");
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_target == 4'd0 |-> o_phys_address == 21'd0) else $error("phys");
endmodule

bind bus_decoder_bank_mapper_unit bdbm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop), .o_target(o_target),
    .o_forward_write(o_forward_write), .o_forward_data(o_forward_data),
    .o_phys_address(o_phys_address)
);
`default_nettype wire
